// File: rtl/emrs_pkg.sv
`timescale 1ns / 1ps
package emrs_pkg;

  localparam int MAX_EXTENTS = 16;
  localparam int IDX_W = $clog2(MAX_EXTENTS);
  localparam logic [12:0] MAX_REQUEST = 13'd4096;
  localparam logic [12:0] BLK_MIN = 13'd512;
  localparam logic [12:0] BLK_MAX = 13'd4096;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_SEEK = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;
  localparam logic [1:0] ACT_NOP = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_END = 2'd1;
  localparam logic [1:0] ST_FAULT = 2'd2;

  localparam logic REG_BLOCK_SIZE = 1'b0;
  localparam logic REG_CONTAINER_SIZE = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  extent_index;
    logic [31:0] extent_start;
    logic [23:0] extent_blocks;
    logic [31:0] new_position;
    logic [12:0] request_length;
  } in_item_t;

  typedef struct packed {
    logic [31:0] device_block;
    logic [11:0] offset_in_block;
    logic [12:0] chunk_length;
    logic        fetch_needed;
    logic [1:0]  status;
    logic [12:0] bytes_so_far;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    K_ACK  = 2'd0,
    K_LOAD = 2'd1,
    K_SEEK = 2'd2,
    K_READ = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  index;
    logic [31:0] start;
    logic [23:0] blocks;
    logic [31:0] position;
    logic [12:0] length;
  } cmd_t;

endpackage

// File: rtl/emrs_front.sv
`timescale 1ns / 1ps
module emrs_front import emrs_pkg::*; (
  input  in_item_t item,
  output cmd_t     cmd
);

  always_comb begin
    cmd.index = item.extent_index;
    cmd.start = item.extent_start;
    cmd.blocks = item.extent_blocks;
    cmd.position = item.new_position;
    cmd.length = (item.request_length > MAX_REQUEST) ? MAX_REQUEST : item.request_length;
    unique case (item.action)
      ACT_LOAD: cmd.kind = K_LOAD;
      ACT_SEEK: cmd.kind = K_SEEK;
      ACT_READ: cmd.kind = K_READ;
      default:  cmd.kind = K_ACK;
    endcase
  end

endmodule

// File: rtl/emrs_fifo.sv
`timescale 1ns / 1ps
module emrs_fifo import emrs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data = entries[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/emrs_back.sv
`timescale 1ns / 1ps
module emrs_back import emrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [12:0] dev_blk_bytes,
  input  logic [31:0] container_size,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_DIV   = 5'b00100,
    S_WALK  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t      state;
  logic [31:0] first_tab [MAX_EXTENTS];
  logic [23:0] len_tab [MAX_EXTENTS];
  logic [31:0] pos;
  logic [31:0] cached;
  logic [12:0] remaining;
  logic [12:0] total;
  logic [12:0] bsz;
  logic [4:0]  div_cnt;
  logic [31:0] dividend;
  logic [12:0] rem;
  logic [IDX_W-1:0] walk_idx;
  logic [28:0] cum;
  logic        more;
  out_item_t   res;

  logic [12:0] bsz_eff;
  logic [13:0] rem_sh;
  logic        rem_ge;
  logic [31:0] fst;
  logic [23:0] ln;
  logic [32:0] end33;
  logic        hit;
  logic [31:0] blk;
  logic [12:0] space;
  logic [12:0] part;
  logic [32:0] np;
  logic        emit_fire;

  function automatic out_item_t pack_res(input logic [31:0] b, input logic [11:0] o,
                                         input logic [12:0] l, input logic f,
                                         input logic [1:0] s, input logic [12:0] t,
                                         input logic la);
    out_item_t r;
    r.device_block = b;
    r.offset_in_block = o;
    r.chunk_length = l;
    r.fetch_needed = f;
    r.status = s;
    r.bytes_so_far = t;
    r.last = la;
    return r;
  endfunction

  always_comb begin
    bsz_eff = dev_blk_bytes;
    if (dev_blk_bytes < BLK_MIN) bsz_eff = BLK_MIN;
    if (dev_blk_bytes > BLK_MAX) bsz_eff = BLK_MAX;
    rem_sh = {rem, dividend[31]};
    rem_ge = rem_sh >= {1'b0, bsz};
    fst = first_tab[walk_idx];
    ln = len_tab[walk_idx];
    end33 = {4'b0, cum} + {9'b0, ln};
    hit = ({1'b0, dividend} >= {4'b0, cum}) && ({1'b0, dividend} < end33);
    blk = fst + (dividend - {3'b0, cum});
    space = bsz - rem;
    part = (space > remaining) ? remaining : space;
    np = {1'b0, pos} + {20'b0, part};
  end

  assign cmd_ready = (state == S_IDLE);
  assign emit_fire = (state == S_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos <= 32'd0;
      cached <= 32'd0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_EXTENTS; i++) begin
        first_tab[i] <= 32'd0;
        len_tab[i] <= 24'd0;
      end
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
        out_data <= res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            res <= pack_res('0, '0, '0, 1'b0, ST_OK, '0, 1'b1);
            more <= 1'b0;
            total <= 13'd0;
            remaining <= cmd.length;
            bsz <= bsz_eff;
            state <= (cmd.kind == K_READ && cmd.length != 13'd0) ? S_CHECK : S_EMIT;
            unique case (cmd.kind)
              K_LOAD: begin
                first_tab[cmd.index[IDX_W-1:0]] <= cmd.start;
                len_tab[cmd.index[IDX_W-1:0]] <= cmd.blocks;
              end
              K_SEEK: pos <= cmd.position;
              default: ;
            endcase
          end
        end
        S_CHECK: begin
          if (pos >= container_size) begin
            res <= pack_res('0, '0, '0, 1'b0, ST_END, total, 1'b1);
            more <= 1'b0;
            state <= S_EMIT;
          end else begin
            dividend <= pos;
            rem <= 13'd0;
            div_cnt <= 5'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= rem_ge ? 13'(rem_sh - {1'b0, bsz}) : rem_sh[12:0];
          dividend <= {dividend[30:0], rem_ge};
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            walk_idx <= '0;
            cum <= 29'd0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (fst == 32'd0 || (hit && blk == 32'd0) ||
              (!hit && walk_idx == IDX_W'(MAX_EXTENTS - 1))) begin
            res <= pack_res('0, '0, '0, 1'b0, ST_FAULT, total, 1'b1);
            more <= 1'b0;
            state <= S_EMIT;
          end else if (hit) begin
            res <= pack_res(blk, rem[11:0], part, (blk != cached), ST_OK,
                            13'(total + part), (remaining == part));
            more <= (remaining != part);
            cached <= blk;
            remaining <= remaining - part;
            total <= total + part;
            pos <= np[32] ? 32'hFFFF_FFFF : np[31:0];
            state <= S_EMIT;
          end else begin
            walk_idx <= walk_idx + IDX_W'(1);
            cum <= end33[28:0];
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            state <= more ? S_CHECK : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_OK) |-> (out_data.last && out_data.chunk_length == 13'd0))
    else $error("status result is not a final empty transaction");
  a_chunk_in_block: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.chunk_length != 13'd0) |->
    ({2'b0, out_data.offset_in_block} + {1'b0, out_data.chunk_length} <= {1'b0, bsz}))
    else $error("chunk crosses a block boundary");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |-> (state == S_IDLE))
    else $error("command taken while busy");
  a_emit_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && (!out_valid || out_ready)) |=> out_valid)
    else $error("result not presented");
`endif

endmodule

// File: rtl/extent_map_read_splitter_core.sv
`timescale 1ns / 1ps
// This block maps reads of a container through an extent table to device
// blocks and splits each read into chunks that never cross a block. Each
// chunk of a read is found by a bit-serial 32-step division of the position
// by the block size followed by a walk over up to sixteen extents, one per
// cycle. A two-entry command queue lets new transactions be taken while a
// result waits.
module extent_map_read_splitter_core import emrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [12:0] dev_blk_bytes;
  logic [31:0] container_size;
  cmd_t        front_cmd;
  cmd_t        q_cmd;
  logic        q_valid;
  logic        q_ready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BLOCK_SIZE) ? {19'b0, dev_blk_bytes} : container_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_blk_bytes <= 13'd512;
      container_size <= 32'd0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_BLOCK_SIZE:     dev_blk_bytes <= pwdata[12:0];
        REG_CONTAINER_SIZE: container_size <= pwdata;
        default: ;
      endcase
    end
  end

  emrs_front u_front (
    .item (in_data),
    .cmd  (front_cmd)
  );

  emrs_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  emrs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .dev_blk_bytes  (dev_blk_bytes),
    .container_size (container_size),
    .cmd_valid      (q_valid),
    .cmd_ready      (q_ready),
    .cmd            (q_cmd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
module tb;
  import emrs_pkg::*;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic      reg_sel;
    logic [31:0] value;
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bit [31:0] ext_first [MAX_EXTENTS];
  bit [23:0] ext_count [MAX_EXTENTS];
  bit [31:0] position;
  bit [31:0] cached;
  bit [12:0] blk_size_reg;
  bit [31:0] container_reg;

  out_item_t chunk_buf [$];
  out_item_t pending_chunks [$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;

  stim_row_t rows [$];

  extent_map_read_splitter_core dut (.*);

  always #4 clk = ~clk;

  function automatic out_item_t ack_result();
    out_item_t r = '0;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic out_item_t stop_result(logic [1:0] st, logic [12:0] total);
    out_item_t r = '0;
    r.status = st;
    r.bytes_so_far = total;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic bit [31:0] lookup_block(bit [31:0] p, bit [12:0] b);
    longint unsigned base = 0;
    longint unsigned span;
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      if (ext_first[i] == 0) break;
      span = longint'(b) * longint'(ext_count[i]);
      if (longint'(p) >= base && longint'(p) < base + span)
        return 32'(longint'(ext_first[i]) + (longint'(p) - base) / longint'(b));
      base += span;
    end
    return '0;
  endfunction

  task automatic split_item(in_item_t it);
    bit [12:0] bsz;
    bit [12:0] remaining;
    bit [12:0] total;
    bit [12:0] part;
    bit [31:0] blk;
    bit [12:0] off;
    longint unsigned np;
    out_item_t r;
    chunk_buf.delete();
    if (it.action == ACT_LOAD) begin
      ext_first[it.extent_index] = it.extent_start;
      ext_count[it.extent_index] = it.extent_blocks;
      chunk_buf.push_back(ack_result());
      return;
    end
    if (it.action != ACT_READ) begin
      if (it.action == ACT_SEEK) position = it.new_position;
      chunk_buf.push_back(ack_result());
      return;
    end
    bsz = blk_size_reg;
    if (bsz < BLK_MIN) bsz = BLK_MIN;
    if (bsz > BLK_MAX) bsz = BLK_MAX;
    remaining = it.request_length;
    if (remaining > MAX_REQUEST) remaining = MAX_REQUEST;
    total = '0;
    if (remaining == 0) begin
      chunk_buf.push_back(ack_result());
      return;
    end
    while (remaining != 0) begin
      if (position >= container_reg) begin
        chunk_buf.push_back(stop_result(ST_END, total));
        return;
      end
      blk = lookup_block(position, bsz);
      if (blk == 0) begin
        chunk_buf.push_back(stop_result(ST_FAULT, total));
        return;
      end
      off = 13'(position % bsz);
      part = bsz - off;
      if (part > remaining) part = remaining;
      r = '0;
      r.device_block = blk;
      r.offset_in_block = off[11:0];
      r.chunk_length = part;
      r.fetch_needed = (blk != cached);
      if (blk != cached) cached = blk;
      remaining -= part;
      total += part;
      np = longint'(position) + longint'(part);
      position = (np > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(np);
      r.status = ST_OK;
      r.bytes_so_far = total;
      r.last = (remaining == 0);
      chunk_buf.push_back(r);
    end
  endtask

  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    split_item(it);
    if (typed) pending_chunks.push_back(typed_res);
    else foreach (chunk_buf[i]) pending_chunks.push_back(chunk_buf[i]);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_chunks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic sel, logic [31:0] val);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= (sel == REG_CONTAINER_SIZE) ? 3'd4 : 3'd0;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_CONTAINER_SIZE) container_reg = val;
    else blk_size_reg = val[12:0];
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata != ((sel == REG_CONTAINER_SIZE) ? val : {19'd0, val[12:0]})) begin
      $display("%0t register readback expected %h actual %h", $time, val, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
    if (!rst && out_valid && out_ready) begin
      if (pending_chunks.size() == 0) begin
        $display("%0t unexpected transaction %p", $time, out_data);
        errors++;
      end else begin
        exp_r = pending_chunks.pop_front();
        if (exp_r.device_block !== out_data.device_block ||
            exp_r.offset_in_block !== out_data.offset_in_block ||
            exp_r.chunk_length !== out_data.chunk_length ||
            exp_r.fetch_needed !== out_data.fetch_needed ||
            exp_r.status !== out_data.status ||
            exp_r.bytes_so_far !== out_data.bytes_so_far ||
            exp_r.last !== out_data.last) begin
          $display("%0t mismatch expected %p actual %p", $time, exp_r, out_data);
          errors++;
        end
      end
    end
  end

  function automatic in_item_t mk(logic [1:0] act, logic [3:0] idx, logic [31:0] st,
                                  logic [23:0] nb, logic [31:0] np, logic [12:0] len);
    in_item_t it;
    it.action = act;
    it.extent_index = idx;
    it.extent_start = st;
    it.extent_blocks = nb;
    it.new_position = np;
    it.request_length = len;
    return it;
  endfunction

  function automatic void add_item(in_item_t it, bit typed = 0, out_item_t r = '0);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.reg_sel = 1'b0;
    row.value = '0;
    row.item = it;
    row.typed = typed;
    row.result = r;
    rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic sel, logic [31:0] val);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.reg_sel = sel;
    row.value = val;
    row.item = '0;
    row.typed = 0;
    row.result = '0;
    rows.push_back(row);
  endfunction

  function automatic in_item_t random_item(int span_limit);
    in_item_t it;
    int pick = $urandom_range(0, 99);
    it = mk(ACT_READ, 4'($urandom), $urandom, 24'($urandom), $urandom, 13'($urandom));
    if (pick < 55) it.request_length = 13'($urandom_range(1, 1500));
    else if (pick < 65) it.request_length = 13'($urandom_range(0, 8191));
    else if (pick < 85) begin
      it.action = ACT_SEEK;
      if ($urandom_range(0, 4) != 0) it.new_position = $urandom_range(0, span_limit);
    end else if (pick < 95) begin
      it.action = ACT_LOAD;
      it.extent_index = 4'($urandom_range(0, 7));
      if ($urandom_range(0, 2) != 0) it.extent_blocks = 24'($urandom_range(1, 8));
    end else it.action = ACT_NOP;
    return it;
  endfunction

  initial begin
    automatic int total_random = 0;
    automatic logic [12:0] bs_pick [5] = '{13'd512, 13'd4096, 13'd1024, 13'd2048, 13'd700};
    automatic int nload;
    automatic int span_limit;

    position = 0;
    cached = 0;
    blk_size_reg = 13'd512;
    container_reg = 0;
    foreach (ext_first[i]) begin
      ext_first[i] = 0;
      ext_count[i] = 0;
    end

    add_item(mk(ACT_READ, '0, '0, '0, '0, 13'd100), 1, stop_result(ST_END, '0));
    add_item(mk(ACT_READ, '0, '0, '0, '0, 13'd0), 1, ack_result());
    add_item(mk(ACT_NOP, 4'hF, '1, '1, '1, '1), 1, ack_result());
    add_cfg(REG_CONTAINER_SIZE, 32'hFFFF_FFFF);
    add_item(mk(ACT_READ, '0, '0, '0, '0, 13'd10), 1, stop_result(ST_FAULT, '0));
    add_item(mk(ACT_LOAD, 4'd0, 32'd100, 24'd4, '0, '0), 1, ack_result());
    add_item(mk(ACT_LOAD, 4'd1, 32'hFFFF_FFFF, 24'hFF_FFFF, '0, '0), 1, ack_result());
    add_item(mk(ACT_LOAD, 4'd15, 32'd7, 24'd1, '0, '0), 1, ack_result());
    add_item(mk(ACT_SEEK, '0, '0, '0, 32'd300, '0), 1, ack_result());
    add_item(mk(ACT_READ, '0, '0, '0, '0, 13'd4096));
    add_item(mk(ACT_READ, '0, '0, '0, '0, 13'd8191));
    add_cfg(REG_BLOCK_SIZE, 32'd0);
    add_item(mk(ACT_SEEK, '0, '0, '0, 32'hFFFF_FFF0, '0), 1, ack_result());
    add_item(mk(ACT_READ, '0, '0, '0, '0, 13'd64));
    add_cfg(REG_BLOCK_SIZE, 32'd8191);
    add_item(mk(ACT_SEEK, '0, '0, '0, 32'd0, '0), 1, ack_result());
    add_item(mk(ACT_READ, '0, '0, '0, '0, 13'd4096));
    add_item(mk(ACT_READ, '0, '0, '0, '0, 13'd1));
    add_cfg(REG_CONTAINER_SIZE, 32'd1000);
    add_item(mk(ACT_SEEK, '0, '0, '0, 32'd990, '0), 1, ack_result());
    add_item(mk(ACT_READ, '0, '0, '0, '0, 13'd50));
    add_cfg(REG_BLOCK_SIZE, 32'd4096);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_reg(rows[i].reg_sel, rows[i].value);
      else send_item(rows[i].item, rows[i].typed, rows[i].result);
    end

    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 14 : (ph < 4) ? 87 : 0;
      recv_idle = (ph < 2) ? 87 : (ph < 4) ? 14 : 0;
      write_reg(REG_BLOCK_SIZE, (ph == 5) ? 32'($urandom_range(0, 8191))
                                          : 32'(bs_pick[$urandom_range(0, 4)]));
      case ($urandom_range(0, 2))
        0: write_reg(REG_CONTAINER_SIZE, 32'hFFFF_FFFF);
        1: write_reg(REG_CONTAINER_SIZE, $urandom_range(0, 30000));
        default: write_reg(REG_CONTAINER_SIZE, $urandom);
      endcase
      nload = $urandom_range(1, 5);
      for (int e = 0; e < nload; e++) begin
        send_item(mk(ACT_LOAD, 4'(e), ($urandom_range(0, 3) == 0) ? $urandom
                     : $urandom_range(1, 5000), 24'($urandom_range(1, 8)), '0, '0), 0, '0);
        total_random++;
      end
      if ($urandom_range(0, 1) != 0) begin
        send_item(mk(ACT_LOAD, 4'(nload), '0, '0, '0, '0), 0, '0);
        total_random++;
      end
      span_limit = nload * 8 * 4096 + 2000;
      for (int n = 0; n < 28; n++) begin
        if (ph == 1 && n == 14) drain();
        send_item(random_item(span_limit), 0, '0);
        total_random++;
      end
    end
    in_valid <= 1'b0;
    while (pending_chunks.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #30ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
